>>> hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, constants and scancode set 1 lookup tables for the PS/2
// scancode decoder with its character ring.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Default ring depth; the ring holds one entry less than this.
    localparam int PSD_RING_DEPTH = 128;

    // Scancode set 1 byte values.
    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] CODE_MASK   = 8'h7F;
    localparam logic [7:0] LSHIFT_CODE = 8'h2A;
    localparam logic [7:0] RSHIFT_CODE = 8'h36;
    localparam logic [7:0] UP_CODE     = 8'h48;
    localparam logic [7:0] DOWN_CODE   = 8'h50;
    localparam logic [7:0] LEFT_CODE   = 8'h4B;
    localparam logic [7:0] RIGHT_CODE  = 8'h4D;

    // Item operation codes.
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [7:0] CFG_ARROW_UP    = 8'd0;
    localparam logic [7:0] CFG_ARROW_DOWN  = 8'd1;
    localparam logic [7:0] CFG_ARROW_LEFT  = 8'd2;
    localparam logic [7:0] CFG_ARROW_RIGHT = 8'd3;

    // Configuration register reset values.
    localparam logic [7:0] ARROW_UP_RST    = 8'd128;
    localparam logic [7:0] ARROW_DOWN_RST  = 8'd129;
    localparam logic [7:0] ARROW_LEFT_RST  = 8'd130;
    localparam logic [7:0] ARROW_RIGHT_RST = 8'd131;

    // Input item.
    typedef struct packed {
        logic       op;
        logic [7:0] scan_byte;
    } psd_in_t;

    // Result item.
    typedef struct packed {
        logic [7:0] read_char;
        logic       queued;
        logic       dropped;
        logic [6:0] fill_level;
    } psd_out_t;

    // Per-item status handed from the control unit to the result stage.
    typedef struct packed {
        logic       rd_hit;
        logic       queued;
        logic       dropped;
        logic [6:0] fill_level;
    } psd_stage_t;

    // Unshifted scancode to ASCII table.
    function automatic logic [7:0] rom_plain(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd1:    ch = 8'h1B;
            7'd2:    ch = 8'h31;
            7'd3:    ch = 8'h32;
            7'd4:    ch = 8'h33;
            7'd5:    ch = 8'h34;
            7'd6:    ch = 8'h35;
            7'd7:    ch = 8'h36;
            7'd8:    ch = 8'h37;
            7'd9:    ch = 8'h38;
            7'd10:   ch = 8'h39;
            7'd11:   ch = 8'h30;
            7'd12:   ch = 8'h2D;
            7'd13:   ch = 8'h3D;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h71;
            7'd17:   ch = 8'h77;
            7'd18:   ch = 8'h65;
            7'd19:   ch = 8'h72;
            7'd20:   ch = 8'h74;
            7'd21:   ch = 8'h79;
            7'd22:   ch = 8'h75;
            7'd23:   ch = 8'h69;
            7'd24:   ch = 8'h6F;
            7'd25:   ch = 8'h70;
            7'd26:   ch = 8'h5B;
            7'd27:   ch = 8'h5D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = 8'h61;
            7'd31:   ch = 8'h73;
            7'd32:   ch = 8'h64;
            7'd33:   ch = 8'h66;
            7'd34:   ch = 8'h67;
            7'd35:   ch = 8'h68;
            7'd36:   ch = 8'h6A;
            7'd37:   ch = 8'h6B;
            7'd38:   ch = 8'h6C;
            7'd39:   ch = 8'h3B;
            7'd40:   ch = 8'h27;
            7'd41:   ch = 8'h60;
            7'd43:   ch = 8'h5C;
            7'd44:   ch = 8'h7A;
            7'd45:   ch = 8'h78;
            7'd46:   ch = 8'h63;
            7'd47:   ch = 8'h76;
            7'd48:   ch = 8'h62;
            7'd49:   ch = 8'h6E;
            7'd50:   ch = 8'h6D;
            7'd51:   ch = 8'h2C;
            7'd52:   ch = 8'h2E;
            7'd53:   ch = 8'h2F;
            7'd55:   ch = 8'h2A;
            7'd57:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Shifted scancode to ASCII table.
    function automatic logic [7:0] rom_shifted(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd1:    ch = 8'h1B;
            7'd2:    ch = 8'h21;
            7'd3:    ch = 8'h40;
            7'd4:    ch = 8'h23;
            7'd5:    ch = 8'h24;
            7'd6:    ch = 8'h25;
            7'd7:    ch = 8'h5E;
            7'd8:    ch = 8'h26;
            7'd9:    ch = 8'h2A;
            7'd10:   ch = 8'h28;
            7'd11:   ch = 8'h29;
            7'd12:   ch = 8'h5F;
            7'd13:   ch = 8'h2B;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h51;
            7'd17:   ch = 8'h57;
            7'd18:   ch = 8'h45;
            7'd19:   ch = 8'h52;
            7'd20:   ch = 8'h54;
            7'd21:   ch = 8'h59;
            7'd22:   ch = 8'h55;
            7'd23:   ch = 8'h49;
            7'd24:   ch = 8'h4F;
            7'd25:   ch = 8'h50;
            7'd26:   ch = 8'h7B;
            7'd27:   ch = 8'h7D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = 8'h41;
            7'd31:   ch = 8'h53;
            7'd32:   ch = 8'h44;
            7'd33:   ch = 8'h46;
            7'd34:   ch = 8'h47;
            7'd35:   ch = 8'h48;
            7'd36:   ch = 8'h4A;
            7'd37:   ch = 8'h4B;
            7'd38:   ch = 8'h4C;
            7'd39:   ch = 8'h3A;
            7'd40:   ch = 8'h22;
            7'd41:   ch = 8'h7E;
            7'd43:   ch = 8'h7C;
            7'd44:   ch = 8'h5A;
            7'd45:   ch = 8'h58;
            7'd46:   ch = 8'h43;
            7'd47:   ch = 8'h56;
            7'd48:   ch = 8'h42;
            7'd49:   ch = 8'h4E;
            7'd50:   ch = 8'h4D;
            7'd51:   ch = 8'h3C;
            7'd52:   ch = 8'h3E;
            7'd53:   ch = 8'h3F;
            7'd55:   ch = 8'h2A;
            7'd57:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/psd_ring_mem.sv
// ----------------------------------------------------------------------------
// psd_ring_mem
// Character ring storage: one write port and one read port, with the read
// data registered.
// ----------------------------------------------------------------------------
module psd_ring_mem
    import psd_pkg::*;
#(
    parameter int DEPTH  = PSD_RING_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Scancode decoder and ring control: shift and prefix flags, arrow code
// registers, ring pointers, and the memory accesses for each accepted item.
// ----------------------------------------------------------------------------
module psd_ctrl
    import psd_pkg::*;
#(
    parameter int RING_DEPTH = PSD_RING_DEPTH,
    parameter int PTR_W      = $clog2(RING_DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  psd_in_t          in_item,
    input  logic             cfg_wr,
    input  logic [7:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    output logic             mem_wr_en,
    output logic [PTR_W-1:0] mem_wr_addr,
    output logic [7:0]       mem_wr_data,
    output logic             mem_rd_en,
    output logic [PTR_W-1:0] mem_rd_addr,
    output psd_stage_t       stage_info
);

    localparam int CNT_W = (PTR_W > 7) ? PTR_W : 7;

    logic             shift_reg, shift_next;
    logic             prefix_reg, prefix_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [7:0]       up_reg, down_reg, left_reg, right_reg;

    logic [7:0]       sc;
    logic [7:0]       ch;
    logic             have;
    logic             push;
    logic             drop;
    logic             rd_hit;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_ext;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign sc     = in_item.scan_byte;
    assign wp_inc = ptr_inc(wp_reg);

    // Decode the item and work out the next flags and pointers.
    always_comb begin
        shift_next  = shift_reg;
        prefix_next = prefix_reg;
        ch          = 8'h00;
        have        = 1'b0;
        rd_hit      = 1'b0;
        rp_next     = rp_reg;
        if (in_item.op == OP_READ) begin
            if (rp_reg != wp_reg) begin
                rd_hit  = 1'b1;
                rp_next = ptr_inc(rp_reg);
            end
        end else if (sc == PREFIX_BYTE) begin
            prefix_next = 1'b1;
        end else if (prefix_reg) begin
            // Extended code: only arrow make codes produce a character.
            prefix_next = 1'b0;
            if ((sc & BREAK_BIT) == 8'h00) begin
                case (sc)
                    UP_CODE: begin
                        ch   = up_reg;
                        have = 1'b1;
                    end
                    DOWN_CODE: begin
                        ch   = down_reg;
                        have = 1'b1;
                    end
                    LEFT_CODE: begin
                        ch   = left_reg;
                        have = 1'b1;
                    end
                    RIGHT_CODE: begin
                        ch   = right_reg;
                        have = 1'b1;
                    end
                    default: begin
                        have = 1'b0;
                    end
                endcase
            end
        end else if ((sc & BREAK_BIT) != 8'h00) begin
            if ((sc & CODE_MASK) == LSHIFT_CODE || (sc & CODE_MASK) == RSHIFT_CODE) begin
                shift_next = 1'b0;
            end
        end else if (sc == LSHIFT_CODE || sc == RSHIFT_CODE) begin
            shift_next = 1'b1;
        end else begin
            ch   = shift_reg ? rom_shifted(sc[6:0]) : rom_plain(sc[6:0]);
            have = (ch != 8'h00);
        end
    end

    // Ring push: a full ring drops the character.
    assign push    = have && (wp_inc != rp_reg);
    assign drop    = have && (wp_inc == rp_reg);
    assign wp_next = push ? wp_inc : wp_reg;

    // Fill level after this item, saturated to the field width.
    assign cnt     = (wp_next - rp_next) + ((wp_next < rp_next) ? PTR_W'(RING_DEPTH) : '0);
    assign cnt_ext = CNT_W'(cnt);

    always_comb begin
        stage_info.rd_hit     = rd_hit;
        stage_info.queued     = push;
        stage_info.dropped    = drop;
        stage_info.fill_level = (cnt_ext > CNT_W'(127)) ? 7'd127 : cnt_ext[6:0];
    end

    // Memory accesses for the accepted item.
    assign mem_wr_en   = accept && push;
    assign mem_wr_addr = wp_reg;
    assign mem_wr_data = ch;
    assign mem_rd_en   = accept && rd_hit;
    assign mem_rd_addr = rp_reg;

    // Flags and pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= 1'b0;
            prefix_reg <= 1'b0;
            wp_reg     <= '0;
            rp_reg     <= '0;
        end else if (accept) begin
            shift_reg  <= shift_next;
            prefix_reg <= prefix_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
        end
    end

    // Arrow code registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg    <= ARROW_UP_RST;
            down_reg  <= ARROW_DOWN_RST;
            left_reg  <= ARROW_LEFT_RST;
            right_reg <= ARROW_RIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_ARROW_UP:    up_reg    <= cfg_data;
                CFG_ARROW_DOWN:  down_reg  <= cfg_data;
                CFG_ARROW_LEFT:  left_reg  <= cfg_data;
                CFG_ARROW_RIGHT: right_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hdl/ps2_scancode_decoder_fifo_top.sv
// ----------------------------------------------------------------------------
// ps2_scancode_decoder_fifo_top
// PS/2 scancode set 1 decoder with a character ring.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one item per handshake: either a scancode byte
//   (op = 0) or a request to read the oldest queued character (op = 1).
//   The m_ channel returns exactly one result item for every input item,
//   in order. The cfg_ channel writes the four arrow key codes by index;
//   it is always ready and should be used while the block is idle.
//   The block accepts one item per cycle while s_ready is high: decode,
//   pointer update and the ring memory access happen in the accept cycle,
//   the memory read data and the item status then sit in the middle stage,
//   and the result then sits in the output register. The single memory read
//   port and registered read data set this two-stage pipeline.
//   When the receiver stalls, the output register holds its item; the
//   middle stage keeps one more, and s_ready drops only when both are full.
//   Reset clears the flags, pointers, pipeline valids and the arrow codes
//   to their defaults. The ring contents are not cleared; the pointers
//   alone mark which entries are live, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module ps2_scancode_decoder_fifo_top
    import psd_pkg::*;
#(
    parameter int RING_DEPTH = PSD_RING_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  psd_in_t    s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output psd_out_t   m_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic             accept;
    logic             advance;
    logic             mem_wr_en;
    logic [PTR_W-1:0] mem_wr_addr;
    logic [7:0]       mem_wr_data;
    logic             mem_rd_en;
    logic [PTR_W-1:0] mem_rd_addr;
    logic [7:0]       mem_rd_data;
    psd_stage_t       stage_info;

    logic             s1_valid_reg;
    psd_stage_t       s1_info_reg;
    logic             m_valid_reg;
    psd_out_t         m_item_reg;

    // Handshakes.
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || advance;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    psd_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_item     (s_item),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .stage_info  (stage_info)
    );

    psd_ring_mem #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Middle stage: waits for the ring read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg <= stage_info;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            m_item_reg.read_char  <= s1_info_reg.rd_hit ? mem_rd_data : 8'h00;
            m_item_reg.queued     <= s1_info_reg.queued;
            m_item_reg.dropped    <= s1_info_reg.dropped;
            m_item_reg.fill_level <= s1_info_reg.fill_level;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> hdl/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for the scancode decoder, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker
    import psd_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input psd_out_t m_item
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // Reset empties the result channel.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A character is either queued or dropped, never both.
    a_queue_xor_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.queued && m_item.dropped))
        else $error("item both queued and dropped");

    // A returned character comes from a read, which queues nothing.
    a_read_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.read_char != 8'h00 |-> !m_item.queued && !m_item.dropped)
        else $error("read item reports a push");

    // A drop happens only with a full, hence nonempty, ring.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.dropped |-> m_item.fill_level != 7'd0)
        else $error("drop reported with empty ring");

endmodule

bind ps2_scancode_decoder_fifo_top psd_checker u_psd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PS/2 scancode set 1 decoder and its character
// ring. A short directed table walks the special cases first. Four random
// phases follow: typing, filling the ring past full, draining it, and a
// mixed phase, each under its own set of arrow key codes. Every result is
// compared with a local decoder model. The sender works in bursts, and the
// receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import psd_pkg::*;

    // Characters the ring can hold, and bench timing figures.
    localparam int          RING_CAP   = PSD_RING_DEPTH - 1;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned DRAIN_WAIT = 8;
    localparam int unsigned MAX_SHOWN  = 10;

    // Register indexes beyond the end of the list; the block ignores them.
    localparam logic [7:0] CFG_PAST_END  = CFG_ARROW_RIGHT + 8'd1;
    localparam logic [7:0] CFG_TOP_INDEX = 8'hFF;

    localparam logic [7:0] ARROW_KEYS [4] = '{UP_CODE, DOWN_CODE, LEFT_CODE, RIGHT_CODE};

    // One row of the directed table; pinned rows carry a hand-written result.
    typedef struct packed {
        psd_in_t  item;
        logic     pinned;
        psd_out_t want;
    } step_t;

    localparam int N_STEPS = 26;
    localparam step_t STEPS [N_STEPS] = '{
        '{'{OP_READ, 8'hFF}, 1'b1, '{8'h00, 1'b0, 1'b0, 7'd0}},
        '{'{OP_SCAN, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 7'd0}},
        '{'{OP_SCAN, 8'h1E}, 1'b1, '{8'h00, 1'b1, 1'b0, 7'd1}},
        '{'{OP_SCAN, 8'h9E}, 1'b1, '{8'h00, 1'b0, 1'b0, 7'd1}},
        '{'{OP_SCAN, LSHIFT_CODE}, 1'b1, '{8'h00, 1'b0, 1'b0, 7'd1}},
        '{'{OP_SCAN, 8'h1E}, 1'b0, '0},
        '{'{OP_SCAN, LSHIFT_CODE | BREAK_BIT}, 1'b0, '0},
        '{'{OP_SCAN, RSHIFT_CODE}, 1'b0, '0},
        '{'{OP_SCAN, 8'h02}, 1'b0, '0},
        '{'{OP_SCAN, RSHIFT_CODE | BREAK_BIT}, 1'b0, '0},
        '{'{OP_SCAN, PREFIX_BYTE}, 1'b0, '0},
        '{'{OP_SCAN, PREFIX_BYTE}, 1'b0, '0},
        '{'{OP_SCAN, UP_CODE}, 1'b1, '{8'h00, 1'b1, 1'b0, 7'd4}},
        '{'{OP_SCAN, PREFIX_BYTE}, 1'b0, '0},
        '{'{OP_SCAN, DOWN_CODE}, 1'b0, '0},
        '{'{OP_SCAN, PREFIX_BYTE}, 1'b0, '0},
        '{'{OP_SCAN, LEFT_CODE}, 1'b0, '0},
        '{'{OP_SCAN, PREFIX_BYTE}, 1'b0, '0},
        '{'{OP_SCAN, RIGHT_CODE}, 1'b0, '0},
        '{'{OP_SCAN, PREFIX_BYTE}, 1'b0, '0},
        '{'{OP_SCAN, UP_CODE | BREAK_BIT}, 1'b0, '0},
        '{'{OP_SCAN, PREFIX_BYTE}, 1'b0, '0},
        '{'{OP_SCAN, 8'h1C}, 1'b0, '0},
        '{'{OP_SCAN, 8'hFF}, 1'b1, '{8'h00, 1'b0, 1'b0, 7'd7}},
        '{'{OP_SCAN, 8'h7F}, 1'b1, '{8'h00, 1'b0, 1'b0, 7'd7}},
        '{'{OP_READ, 8'h00}, 1'b1, '{8'h61, 1'b0, 1'b0, 7'd6}}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    psd_in_t    s_item    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    psd_out_t   m_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    // Decoder model state.
    logic [7:0] arrow_code [4];
    bit         shift_held;
    bit         ext_prefix;
    logic [7:0] char_fifo [$];

    // Results still owed by the block, oldest first.
    psd_out_t   pending_results [$];
    int unsigned mismatches = 0;

    // Sender burst and receiver stall control.
    int unsigned burst_left = 0;
    bit          hold_req   = 1'b0;
    bit          hold_seen  = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned mode_left  = 0;
    int unsigned ready_pct  = 100;

    ps2_scancode_decoder_fifo_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Scancode set 1 to ASCII lookup; dots in the strings are filled in below.
    function automatic logic [7:0] key_to_ascii(bit shifted, logic [6:0] code);
        string keys;
        keys = shifted ? "..!@#$%^&*()_+..QWERTYUIOP{}..ASDFGHJKL:\"~.|ZXCVBNM<>?.*. .."
                       : "..1234567890-=..qwertyuiop[]..asdfghjkl;'..\\zxcvbnm,./.*. ..";
        case (code)
            7'd1:    return 8'h1B;
            7'd14:   return 8'h08;
            7'd15:   return 8'h09;
            7'd28:   return 8'h0A;
            7'd41:   return shifted ? 8'h7E : 8'h60;
            7'd0, 7'd29, 7'd42, 7'd54, 7'd56, 7'd58, 7'd59: return 8'h00;
            default: return (code < 7'd60) ? 8'(keys[code]) : 8'h00;
        endcase
    endfunction

    // Applies one accepted item to the model and returns the result it owes.
    function automatic psd_out_t decode_item(psd_in_t it);
        psd_out_t   r;
        logic [7:0] ch;
        bit         have;
        r    = '0;
        ch   = 8'h00;
        have = 1'b0;
        if (it.op == OP_READ) begin
            if (char_fifo.size() != 0) r.read_char = char_fifo.pop_front();
        end else if (it.scan_byte == PREFIX_BYTE) begin
            ext_prefix = 1'b1;
        end else if (ext_prefix) begin
            // Only arrow make codes mean anything after the prefix.
            ext_prefix = 1'b0;
            have       = 1'b1;
            case (it.scan_byte)
                UP_CODE:    ch = arrow_code[CFG_ARROW_UP];
                DOWN_CODE:  ch = arrow_code[CFG_ARROW_DOWN];
                LEFT_CODE:  ch = arrow_code[CFG_ARROW_LEFT];
                RIGHT_CODE: ch = arrow_code[CFG_ARROW_RIGHT];
                default:    have = 1'b0;
            endcase
        end else if ((it.scan_byte & BREAK_BIT) != 0) begin
            if ((it.scan_byte & CODE_MASK) == LSHIFT_CODE ||
                (it.scan_byte & CODE_MASK) == RSHIFT_CODE) begin
                shift_held = 1'b0;
            end
        end else if (it.scan_byte == LSHIFT_CODE || it.scan_byte == RSHIFT_CODE) begin
            shift_held = 1'b1;
        end else begin
            ch   = key_to_ascii(shift_held, it.scan_byte[6:0]);
            have = (ch != 8'h00);
        end

        if (have) begin
            if (char_fifo.size() < RING_CAP) begin
                char_fifo.push_back(ch);
                r.queued = 1'b1;
            end else begin
                r.dropped = 1'b1;
            end
        end
        r.fill_level = (char_fifo.size() > 127) ? 7'd127 : 7'(char_fifo.size());
        return r;
    endfunction

    function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("tb: %s mismatch: expected %0h, got %0h", what, want, got);
        end
    endfunction

    // Offers one item, with a random gap between bursts, and books its result.
    task automatic offer_item(input psd_in_t it, input bit pinned, input psd_out_t want);
        psd_out_t pred;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        pred = decode_item(it);
        pending_results.push_back(pinned ? want : pred);
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Writes one register; cfg_valid is lowered by the caller after the last write.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= CFG_ARROW_RIGHT) arrow_code[idx[1:0]] = val;
    endtask

    task automatic load_arrow_codes(input logic [7:0] up, input logic [7:0] down,
                                    input logic [7:0] left, input logic [7:0] right,
                                    input bit with_stray);
        write_reg(CFG_ARROW_UP, up);
        if (with_stray) write_reg(CFG_PAST_END, 8'($urandom));
        write_reg(CFG_ARROW_DOWN, down);
        write_reg(CFG_ARROW_LEFT, left);
        if (with_stray) write_reg(CFG_TOP_INDEX, 8'($urandom));
        write_reg(CFG_ARROW_RIGHT, right);
        cfg_valid <= 1'b0;
    endtask

    // Random keyboard traffic: mostly well-formed key sequences, some noise.
    task automatic run_phase(input int unsigned n_items, input int unsigned read_pct,
                             input bit long_hold);
        int unsigned sent;
        int unsigned pick;
        bit          hold_pending;
        logic [7:0]  key;
        psd_in_t     seq [$];
        sent         = 0;
        hold_pending = long_hold;
        while (sent < n_items) begin
            if (hold_pending && sent >= n_items / 2) begin
                // Long receiver hold-off while the sender keeps offering.
                hold_req    <= ~hold_req;
                burst_left   = 80;
                hold_pending = 1'b0;
            end
            seq.delete();
            pick = $urandom_range(0, 99);
            if (pick < read_pct) begin
                seq.push_back('{OP_READ, 8'($urandom)});
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    key = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 8'h39))
                                                       : 8'($urandom_range(0, 8'h7F));
                    seq.push_back('{OP_SCAN, key});
                    if ($urandom_range(0, 1)) seq.push_back('{OP_SCAN, key | BREAK_BIT});
                end else if (pick < 65) begin
                    seq.push_back('{OP_SCAN, $urandom_range(0, 1) ? LSHIFT_CODE : RSHIFT_CODE});
                end else if (pick < 75) begin
                    key = $urandom_range(0, 1) ? LSHIFT_CODE : RSHIFT_CODE;
                    seq.push_back('{OP_SCAN, key | BREAK_BIT});
                end else if (pick < 87) begin
                    key = ARROW_KEYS[$urandom_range(0, 3)];
                    seq.push_back('{OP_SCAN, PREFIX_BYTE});
                    seq.push_back('{OP_SCAN, key});
                    seq.push_back('{OP_SCAN, PREFIX_BYTE});
                    seq.push_back('{OP_SCAN, key | BREAK_BIT});
                end else if (pick < 93) begin
                    seq.push_back('{OP_SCAN, PREFIX_BYTE});
                    seq.push_back('{OP_SCAN, 8'($urandom)});
                end else begin
                    seq.push_back('{OP_SCAN, 8'($urandom)});
                end
            end
            foreach (seq[i]) offer_item(seq[i], 1'b0, '0);
            sent += seq.size();
        end
    endtask

    // Receiver: a changing ready rate, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(16, 80);
                case ($urandom_range(0, 3))
                    0:       ready_pct <= 100;
                    1:       ready_pct <= 75;
                    2:       ready_pct <= 40;
                    default: ready_pct <= 10;
                endcase
            end else begin
                mode_left <= mode_left - 1;
            end
            m_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Result checker: each accepted result against the oldest owed one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", 0, m_item);
            end else begin
                psd_out_t want;
                want = pending_results.pop_front();
                if (want.read_char != m_item.read_char)
                    flag_mismatch("read_char", want.read_char, m_item.read_char);
                if (want.queued != m_item.queued)
                    flag_mismatch("queued", want.queued, m_item.queued);
                if (want.dropped != m_item.dropped)
                    flag_mismatch("dropped", want.dropped, m_item.dropped);
                if (want.fill_level != m_item.fill_level)
                    flag_mismatch("fill_level", want.fill_level, m_item.fill_level);
            end
        end
    end

    // Main sequence.
    initial begin
        arrow_code[CFG_ARROW_UP]    = ARROW_UP_RST;
        arrow_code[CFG_ARROW_DOWN]  = ARROW_DOWN_RST;
        arrow_code[CFG_ARROW_LEFT]  = ARROW_LEFT_RST;
        arrow_code[CFG_ARROW_RIGHT] = ARROW_RIGHT_RST;
        shift_held = 1'b0;
        ext_prefix = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under the reset arrow codes.
        for (int i = 0; i < N_STEPS; i++) begin
            offer_item(STEPS[i].item, STEPS[i].pinned, STEPS[i].want);
        end

        // Typing with all arrow codes at zero.
        wait_drained();
        load_arrow_codes(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        run_phase(120, 30, 1'b0);

        // Few reads: the ring fills and drops characters; long receiver stall.
        wait_drained();
        load_arrow_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        run_phase(400, 2, 1'b1);

        // Mostly reads: the ring drains down to empty.
        wait_drained();
        load_arrow_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        run_phase(180, 85, 1'b0);

        // Mixed traffic.
        wait_drained();
        load_arrow_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        run_phase(80, 35, 1'b0);

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule
